/* rtl/core/oeps_pkg.sv */
// ----------------------------------------------------------------------------
// oeps_pkg: shared types and constants of the odd/even partition sorter
// Holds the default capacity, the word width, the sort key layout and the
// structures passed along the row of sorting cells.
// ----------------------------------------------------------------------------
package oeps_pkg;

	localparam int OEPS_CAPACITY = 32;
	localparam int WORD_W        = 32;
	localparam int KEY_W         = WORD_W + 1;

	typedef struct packed {
		logic              vld;
		logic [WORD_W-1:0] val;
	} oeps_entry_t;

	typedef struct packed {
		logic              insert;
		logic              shift;
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] val;
	} oeps_ctrl_t;

	// Odd values order before even ones, then signed ascending order.
	function automatic logic [KEY_W-1:0] sort_key(input logic [WORD_W-1:0] v);
		sort_key = {~v[0], ~v[WORD_W-1], v[WORD_W-2:0]};
	endfunction

endpackage

/* rtl/core/odd_even_partition_sorter.sv */
// ----------------------------------------------------------------------------
// odd_even_partition_sorter: streaming odd/even partition sorter
// Collects a set of signed values and streams them back, odd values first.
// ----------------------------------------------------------------------------
// Values are accepted one per cycle into a row of CAPACITY cells that keeps
// them in order as they arrive: odd values first, each group ascending as
// signed numbers. The transfer marked by tlast is stored like any other and
// starts the output run; the run then streams out at one value per cycle,
// while the receiver is ready, from the head cell, the last value marked by
// tlast and every value flagged in tuser if any value of the set found the
// row full and was dropped. No input is taken while a run is draining, so
// the input and the output of a set never overlap.
// ----------------------------------------------------------------------------
module odd_even_partition_sorter #(
	parameter int CAPACITY = oeps_pkg::OEPS_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [oeps_pkg::WORD_W-1:0] s_axis_tdata,  // sample_value
	input  logic                      s_axis_tlast,  // final_item
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [oeps_pkg::WORD_W-1:0] m_axis_tdata,  // sorted_value
	output logic                      m_axis_tlast,  // end_of_run
	output logic                      m_axis_tuser   // dropped
);
	import oeps_pkg::*;

	oeps_entry_t entries [CAPACITY+1];
	logic [CAPACITY-1:0] gts;
	logic [CAPACITY:0] vlds;
	oeps_ctrl_t ctrl;
	logic drain_q;
	logic overflow_q;
	logic in_xfer;
	logic out_xfer;
	logic full;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign full     = entries[CAPACITY-1].vld;

	assign entries[CAPACITY] = '{vld: 1'b0, val: '0};

	assign ctrl.insert = in_xfer && !full;
	assign ctrl.shift  = out_xfer;
	assign ctrl.key    = sort_key(s_axis_tdata);
	assign ctrl.val    = s_axis_tdata;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		oeps_entry_t prev_e;
		logic        prev_g;
		if (i == 0) begin : g_head
			assign prev_e = '{vld: 1'b0, val: '0};
			assign prev_g = 1'b0;
		end else begin : g_body
			assign prev_e = entries[i-1];
			assign prev_g = gts[i-1];
		end
		oeps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_entry (prev_e),
			.prev_gt    (prev_g),
			.next_entry (entries[i+1]),
			.entry      (entries[i]),
			.gt         (gts[i])
		);
	end

	for (genvar i = 0; i <= CAPACITY; i++) begin : g_vld
		assign vlds[i] = entries[i].vld;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			if (in_xfer && s_axis_tlast) begin
				drain_q <= 1'b1;
			end else if (out_xfer && m_axis_tlast) begin
				drain_q <= 1'b0;
			end
			if (in_xfer && full) begin
				overflow_q <= 1'b1;
			end else if (out_xfer && m_axis_tlast) begin
				overflow_q <= 1'b0;
			end
		end
	end

	assign s_axis_tready = !drain_q;
	assign m_axis_tvalid = drain_q && entries[0].vld;
	assign m_axis_tdata  = entries[0].val;
	assign m_axis_tlast  = !entries[1].vld;
	assign m_axis_tuser  = overflow_q;

`ifndef SYNTHESIS
	a_fill_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(vlds & (vlds + (CAPACITY+1)'(1))) == '0)
		else $error("cell row holds a gap");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> entries[0].vld)
		else $error("draining with an empty head cell");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tlast) |=> (s_axis_tready && !entries[0].vld && !overflow_q))
		else $error("state not cleared after the end of a run");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && full) |=> (overflow_q && entries[CAPACITY-1].vld))
		else $error("dropped transfer not recorded");
`endif

endmodule

/* rtl/core/oeps_cell.sv */
// ----------------------------------------------------------------------------
// oeps_cell: one slot of the insertion row
// Holds one value. On insertion it keeps its value, takes the new one or takes
// its left neighbour's; while draining it takes its right neighbour's value.
// ----------------------------------------------------------------------------
module oeps_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oeps_pkg::oeps_ctrl_t ctrl,
	input  oeps_pkg::oeps_entry_t prev_entry,
	input  logic                 prev_gt,
	input  oeps_pkg::oeps_entry_t next_entry,
	output oeps_pkg::oeps_entry_t entry,
	output logic                 gt
);
	import oeps_pkg::*;

	oeps_entry_t entry_q;
	oeps_entry_t entry_d;

	// An empty slot counts as larger than any value.
	assign gt = !entry_q.vld || (sort_key(entry_q.val) > ctrl.key);

	always_comb begin
		entry_d = entry_q;
		if (ctrl.shift) begin
			entry_d = next_entry;
		end else if (ctrl.insert && gt) begin
			if (!prev_gt) begin
				entry_d.vld = 1'b1;
				entry_d.val = ctrl.val;
			end else begin
				entry_d = prev_entry;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the odd/even partition sorter
// Streams sets of signed words into the sorter and compares each output
// transfer with a run predicted in the bench: odd words first, each parity
// group in ascending signed order, end of run marked, drop flag on overflow.
// Both sides idle at random outside a calm window, and the receiver holds off
// once for a long stretch so that a run stays draining and the input stalls.
// ----------------------------------------------------------------------------
module tb_top;

	import oeps_pkg::*;

	localparam int CAP          = OEPS_CAPACITY;
	localparam int STALL_LIMIT  = 2000;
	localparam int CALM_FIRST   = 40;
	localparam int CALM_LAST    = 160;
	localparam int HOLD_START   = 200;
	localparam int HOLD_LEN     = 300;
	localparam int RANDOM_ITEMS = 80;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last;
	} sample_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              last;
		logic              dropped;
	} sorted_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [WORD_W-1:0] s_axis_tdata  = '0;
	logic              s_axis_tlast  = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [WORD_W-1:0] m_axis_tdata;
	logic              m_axis_tlast;
	logic              m_axis_tuser;

	sample_t           pending_samples[$];
	sorted_t           sorted_due[$];

	logic [WORD_W-1:0] held_vals[CAP];
	int                held_count = 0;
	bit                held_over  = 1'b0;

	int                cycle       = 0;
	int                quiet_count = 0;
	int                hold_left   = 0;
	int                mismatches  = 0;
	bit                send_idle;
	sorted_t           got;
	sorted_t           want;

	odd_even_partition_sorter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Odd words lead; within a parity group the order is signed ascending.
	function automatic bit goes_first(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		if (a[0] != b[0])
			return a[0];
		return $signed(a) < $signed(b);
	endfunction

	task automatic absorb_sample(input sample_t s);
		logic [WORD_W-1:0] run[CAP];
		logic [WORD_W-1:0] key;
		sorted_t           r;
		int                i;
		int                j;
		if (held_count < CAP) begin
			held_vals[held_count] = s.value;
			held_count++;
		end else begin
			held_over = 1'b1;
		end
		if (!s.last)
			return;
		for (i = 0; i < held_count; i++)
			run[i] = held_vals[i];
		for (i = 1; i < held_count; i++) begin
			key = run[i];
			j = i;
			while (j > 0 && goes_first(key, run[j-1])) begin
				run[j] = run[j-1];
				j--;
			end
			run[j] = key;
		end
		for (i = 0; i < held_count; i++) begin
			r.value   = run[i];
			r.last    = (i == held_count - 1);
			r.dropped = held_over;
			sorted_due.push_back(r);
		end
		held_count = 0;
		held_over  = 1'b0;
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		logic [WORD_W-1:0] base;
		case ($urandom_range(0, 5))
			3: return WORD_W'($urandom_range(0, 16)) - WORD_W'(8);
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			5: begin
				base = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFF0;
				return base + WORD_W'($urandom_range(0, 15));
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_set(input int len);
		sample_t s;
		int      i;
		for (i = 0; i < len; i++) begin
			s.value = pick_word();
			s.last  = (i == len - 1);
			pending_samples.push_back(s);
		end
	endtask

	task automatic queue_word(input logic [WORD_W-1:0] v, input logic last);
		sample_t s;
		s.value = v;
		s.last  = last;
		pending_samples.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle <= 0;
		end else begin
			cycle <= cycle + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_sample(pending_samples[0]);
				void'(pending_samples.pop_front());
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				send_idle = (cycle < CALM_FIRST || cycle >= CALM_LAST)
					&& ($urandom_range(0, 99) < 6);
				if (pending_samples.size() > 0 && !send_idle) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= pending_samples[0].value;
					s_axis_tlast  <= pending_samples[0].last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.value   = m_axis_tdata;
				got.last    = m_axis_tlast;
				got.dropped = m_axis_tuser;
				if (sorted_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Unexpected transfer: value %h last %b dropped %b",
							got.value, got.last, got.dropped);
				end else begin
					want = sorted_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("Mismatch: expected %h/%b/%b, got %h/%b/%b",
								want.value, want.last, want.dropped,
								got.value, got.last, got.dropped);
					end
				end
			end
			if (cycle == HOLD_START)
				hold_left = HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (cycle >= CALM_FIRST && cycle < CALM_LAST) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 6);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_count <= 0;
			else
				quiet_count <= quiet_count + 1;
			if (quiet_count >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int random_total;
		int len;
		// Extremes of the signed range with both parities, negatives included.
		queue_word(32'h8000_0000, 1'b0);
		queue_word(32'h7FFF_FFFF, 1'b0);
		queue_word(32'h0000_0000, 1'b0);
		queue_word(32'hFFFF_FFFF, 1'b0);
		queue_word(32'h0000_0001, 1'b0);
		queue_word(32'h8000_0001, 1'b0);
		queue_word(32'h7FFF_FFFE, 1'b0);
		queue_word(32'h0000_0002, 1'b0);
		queue_word(32'hFFFF_FFFE, 1'b1);
		// Single-word sets, one odd and one even.
		queue_word(32'hFFFF_FFFD, 1'b1);
		queue_word(32'h0000_0010, 1'b1);
		// Repeated words within a set.
		queue_word(32'h0000_0005, 1'b0);
		queue_word(32'hFFFF_FFFC, 1'b0);
		queue_word(32'h0000_0005, 1'b0);
		queue_word(32'hFFFF_FFFC, 1'b0);
		queue_word(32'h0000_0005, 1'b1);
		// A set that exactly fills the store, then one whose final word is dropped.
		queue_set(CAP);
		queue_set(CAP + 1);
		random_total = 0;
		while (random_total < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(CAP - 2, CAP + 4)
				: $urandom_range(1, 8);
			queue_set(len);
			random_total += len;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_samples.size() != 0 || sorted_due.size() != 0)
			@(posedge clk);
		repeat (CAP + 20) @(posedge clk);
		if (mismatches == 0 && sorted_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* odd_even_partition_sorter.f */
rtl/core/oeps_pkg.sv
rtl/core/oeps_cell.sv
rtl/core/odd_even_partition_sorter.sv
sim/tb_top.sv
